// File: hw/rtl/stip_pkg.sv
package stip_pkg;

   localparam int MAX_STRING_LEN_DEF = 4096;
   localparam int RESULT_WIDTH_DEF   = 64;

   localparam int VALUE_W = 64;
   localparam int BASE_W  = 6;
   localparam int CHAR_W  = 8;
   localparam int DIGIT_W = 6;

   localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
   localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
   localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
   localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
   localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
   localparam logic [BASE_W-1:0] BASE_ONE   = 6'd1;
   localparam logic [BASE_W-1:0] BASE_TWO   = 6'd2;
   localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;

   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
   localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
   localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

   localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'd63;

   localparam logic [0:0] CSR_NUMBER_BASE = 1'b0;
   localparam logic [0:0] CSR_RESULT_KIND = 1'b1;

   typedef enum logic [2:0] {
      PH_SPACE,
      PH_SIGNED,
      PH_ZERO,
      PH_HEXPFX,
      PH_DIGITS,
      PH_DONE,
      PH_BADBASE
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_BAD_BASE,
      ST_NONE,
      ST_RANGE
   } status_type;

   // per-string parse state, carried between characters
   typedef struct packed {
      phase_type          phase;
      logic [VALUE_W-1:0] acc;
      logic               ovf;
      logic               is_negative;
      logic [BASE_W-1:0]  base;
      logic               any_digit;
   } state_type;

   // what the final character leaves for the clamp stage
   typedef struct packed {
      phase_type          phase;
      logic [VALUE_W-1:0] acc;
      logic               ovf;
      logic               is_negative;
      logic               any_digit;
      logic               unsigned_kind;
   } final_type;

   function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] t;
      t = CH_NUL;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         t = c - CH_ZERO;
      end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
         t = c - CH_UP_A + 8'd10;
      end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
         t = c - CH_LO_A + 8'd10;
      end else begin
         t = CHAR_W'(DIGIT_NONE);
      end
      return t[DIGIT_W-1:0];
   endfunction

   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

endpackage

// File: hw/rtl/stip_step.sv
module stip_step #(
   parameter int MAX_STRING_LEN = stip_pkg::MAX_STRING_LEN_DEF,
   parameter int POS_W          = $clog2(MAX_STRING_LEN + 1)
) (
   input  stip_pkg::state_type              cur_st,
   input  logic [POS_W-1:0]                 cur_pos,
   input  logic [POS_W-1:0]                 cur_stop,
   input  logic [stip_pkg::CHAR_W-1:0]      char_code,
   input  logic [stip_pkg::BASE_W-1:0]      number_base,
   output stip_pkg::state_type              nxt_st,
   output logic [POS_W-1:0]                 nxt_pos,
   output logic [POS_W-1:0]                 nxt_stop
);

   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_STRING_LEN);
   localparam int PROD_W = stip_pkg::VALUE_W + stip_pkg::BASE_W;

   logic [stip_pkg::CHAR_W-1:0]  c;
   logic [stip_pkg::DIGIT_W-1:0] d;
   logic [stip_pkg::BASE_W-1:0]  eb;
   logic [stip_pkg::BASE_W-1:0]  db;
   logic [PROD_W-1:0]            prod;
   logic                         in_range;
   logic                         start;
   logic                         do_digit;

   // characters past the length limit behave as unconvertible
   assign in_range = cur_pos < POS_LIMIT;
   assign c        = in_range ? char_code : stip_pkg::CH_NUL;
   assign d        = stip_pkg::digit_of(c);
   assign nxt_pos  = in_range ? cur_pos + POS_W'(1) : cur_pos;

   always_comb begin
      nxt_st   = cur_st;
      nxt_stop = cur_stop;
      start    = 1'b0;
      do_digit = 1'b0;
      eb       = cur_st.base;

      // base is latched on the first character of each string
      if (cur_pos == '0 && cur_st.phase == stip_pkg::PH_SPACE) begin
         eb = number_base;
         if (number_base == stip_pkg::BASE_ONE || number_base > stip_pkg::BASE_MAX) begin
            nxt_st.phase = stip_pkg::PH_BADBASE;
         end
      end
      nxt_st.base = eb;
      db          = eb;

      case (nxt_st.phase)
         stip_pkg::PH_SPACE: begin
            if (stip_pkg::is_space(c)) begin
               nxt_st.phase = stip_pkg::PH_SPACE;
            end else if (c == stip_pkg::CH_PLUS) begin
               nxt_st.phase = stip_pkg::PH_SIGNED;
            end else if (c == stip_pkg::CH_MINUS) begin
               nxt_st.is_negative = 1'b1;
               nxt_st.phase       = stip_pkg::PH_SIGNED;
            end else begin
               start = 1'b1;
            end
         end
         stip_pkg::PH_SIGNED: begin
            start = 1'b1;
         end
         stip_pkg::PH_ZERO: begin
            if (c == stip_pkg::CH_LO_X || c == stip_pkg::CH_UP_X) begin
               nxt_st.base  = stip_pkg::BASE_HEX;
               nxt_st.phase = stip_pkg::PH_HEXPFX;
            end else begin
               if (eb == stip_pkg::BASE_AUTO) begin
                  db = stip_pkg::BASE_OCT;
               end
               nxt_st.base = db;
               do_digit    = 1'b1;
            end
         end
         stip_pkg::PH_HEXPFX, stip_pkg::PH_DIGITS: begin
            do_digit = 1'b1;
         end
         default: begin
         end
      endcase

      if (start) begin
         if (c == stip_pkg::CH_ZERO &&
             (eb == stip_pkg::BASE_AUTO || eb == stip_pkg::BASE_HEX)) begin
            // leading zero counts as a digit, may still turn into a 0x prefix
            nxt_st.any_digit = 1'b1;
            nxt_st.acc       = '0;
            nxt_stop         = cur_pos + POS_W'(1);
            nxt_st.phase     = stip_pkg::PH_ZERO;
         end else begin
            if (eb == stip_pkg::BASE_AUTO) begin
               db = stip_pkg::BASE_DEC;
            end
            nxt_st.base = db;
            do_digit    = 1'b1;
         end
      end

      prod = PROD_W'(cur_st.acc) * PROD_W'(db) + PROD_W'(d);

      if (do_digit) begin
         if (db >= stip_pkg::BASE_TWO && d < db) begin
            nxt_st.acc       = prod[stip_pkg::VALUE_W-1:0];
            nxt_st.ovf       = cur_st.ovf | (|prod[PROD_W-1:stip_pkg::VALUE_W]);
            nxt_st.any_digit = 1'b1;
            nxt_stop         = cur_pos + POS_W'(1);
            nxt_st.phase     = stip_pkg::PH_DIGITS;
         end else begin
            nxt_st.phase = stip_pkg::PH_DONE;
         end
      end
   end

endmodule

// File: hw/rtl/stip_clamp.sv
module stip_clamp #(
   parameter int RESULT_WIDTH = stip_pkg::RESULT_WIDTH_DEF,
   parameter int POS_W        = 13
) (
   input  stip_pkg::final_type                fin,
   input  logic [POS_W-1:0]                   stop,
   output logic [stip_pkg::VALUE_W-1:0]       value,
   output stip_pkg::status_type               status,
   output logic [POS_W-1:0]                   end_offset
);

   localparam logic [stip_pkg::VALUE_W-1:0] UMAX =
      {stip_pkg::VALUE_W{1'b1}} >> (stip_pkg::VALUE_W - RESULT_WIDTH);
   localparam logic [stip_pkg::VALUE_W-1:0] SMAX = UMAX >> 1;

   always_comb begin
      value      = '0;
      status     = stip_pkg::ST_OK;
      end_offset = '0;
      if (fin.phase == stip_pkg::PH_BADBASE) begin
         status = stip_pkg::ST_BAD_BASE;
      end else if (!fin.any_digit) begin
         status = stip_pkg::ST_NONE;
      end else begin
         end_offset = stop;
         if (!fin.unsigned_kind) begin
            if (!fin.is_negative) begin
               if (fin.ovf || fin.acc > SMAX) begin
                  value  = SMAX;
                  status = stip_pkg::ST_RANGE;
               end else begin
                  value = fin.acc;
               end
            end else begin
               // ~SMAX is the most negative value, already sign-extended
               if (fin.ovf || fin.acc > SMAX + 64'd1) begin
                  value  = ~SMAX;
                  status = stip_pkg::ST_RANGE;
               end else begin
                  value = '0 - fin.acc;
               end
            end
         end else begin
            if (fin.is_negative) begin
               if (fin.ovf || fin.acc != '0) begin
                  status = stip_pkg::ST_RANGE;
               end
            end else if (fin.ovf || fin.acc > UMAX) begin
               value  = UMAX;
               status = stip_pkg::ST_RANGE;
            end else begin
               value = fin.acc;
            end
         end
      end
   end

endmodule

// File: hw/rtl/string_to_integer_parser_unit.sv
// Streaming strtol/strtoul parser. Send one string byte per req transfer, with
// req_tlast on the final byte; that transfer yields exactly one rsp transfer and
// no other byte yields any. The unit takes one byte every cycle while the result
// side does not hold it back: each byte goes through an input register, a single
// step stage whose 64x6 multiply-add of the accumulator sets the cycle time, the
// snapshot register, and a clamp stage into the result register. Strings may
// follow each other with no gap. csr writes (index 0 number_base, index 1
// result_kind) must only be made while the unit holds no string in flight.
module string_to_integer_parser_unit #(
   parameter int MAX_STRING_LEN = stip_pkg::MAX_STRING_LEN_DEF,
   parameter int RESULT_WIDTH   = stip_pkg::RESULT_WIDTH_DEF,
   parameter int POS_W          = $clog2(MAX_STRING_LEN + 1),
   parameter int RSP_W          = ((stip_pkg::VALUE_W + 2 + POS_W + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] char_code
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [RSP_W-1:0]              rsp_tdata,   // value, status, end_offset
   input  logic                          csr_we,
   input  logic [0:0]                    csr_addr,
   input  logic [stip_pkg::BASE_W-1:0]   csr_wdata
);

   logic [stip_pkg::BASE_W-1:0] base_ff;
   logic                        kind_ff;

   logic                        in_valid_ff, in_valid_in;
   logic [stip_pkg::CHAR_W-1:0] in_char_ff;
   logic                        in_last_ff;

   stip_pkg::state_type         st_ff, st_in, step_st;
   logic [POS_W-1:0]            pos_ff, pos_in, step_pos;
   logic [POS_W-1:0]            stop_ff, stop_in, step_stop;

   logic                        snap_valid_ff, snap_valid_in;
   stip_pkg::final_type         snap_ff;
   logic [POS_W-1:0]            snap_stop_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [stip_pkg::VALUE_W-1:0] rsp_value_ff, fin_value;
   stip_pkg::status_type        rsp_status_ff, fin_status;
   logic [POS_W-1:0]            rsp_end_ff, fin_end;

   logic                        out_free, snap_move, snap_free, step_go, step_fin;

   stip_pkg::state_type         st_clear;

   assign st_clear = '{phase: stip_pkg::PH_SPACE, acc: '0, ovf: 1'b0,
                       is_negative: 1'b0, base: '0, any_digit: 1'b0};

   // pipeline flow control
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign snap_move  = snap_valid_ff && out_free;
   assign snap_free  = !snap_valid_ff || snap_move;
   assign step_go    = in_valid_ff && (!in_last_ff || snap_free);
   assign step_fin   = step_go && in_last_ff;
   assign req_tready = !in_valid_ff || step_go;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_end_ff, rsp_status_ff, rsp_value_ff});

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= stip_pkg::BASE_RESET;
         kind_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            stip_pkg::CSR_NUMBER_BASE: base_ff <= csr_wdata;
            stip_pkg::CSR_RESULT_KIND: kind_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // input register
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   stip_step #(
      .MAX_STRING_LEN (MAX_STRING_LEN),
      .POS_W          (POS_W)
   ) u_step (
      .cur_st      (st_ff),
      .cur_pos     (pos_ff),
      .cur_stop    (stop_ff),
      .char_code   (in_char_ff),
      .number_base (base_ff),
      .nxt_st      (step_st),
      .nxt_pos     (step_pos),
      .nxt_stop    (step_stop)
   );

   // parse state returns to its clear value after each final byte
   always_comb begin
      st_in   = st_ff;
      pos_in  = pos_ff;
      stop_in = stop_ff;
      if (step_fin) begin
         st_in   = st_clear;
         pos_in  = '0;
         stop_in = '0;
      end else if (step_go) begin
         st_in   = step_st;
         pos_in  = step_pos;
         stop_in = step_stop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= st_clear;
         pos_ff  <= '0;
         stop_ff <= '0;
      end else begin
         st_ff   <= st_in;
         pos_ff  <= pos_in;
         stop_ff <= stop_in;
      end
   end

   // snapshot of the finished string
   assign snap_valid_in = step_fin ? 1'b1 : (snap_move ? 1'b0 : snap_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fin) begin
         snap_ff <= '{phase: step_st.phase, acc: step_st.acc, ovf: step_st.ovf,
                      is_negative: step_st.is_negative,
                      any_digit: step_st.any_digit, unsigned_kind: kind_ff};
         snap_stop_ff <= step_stop;
      end
   end

   stip_clamp #(
      .RESULT_WIDTH (RESULT_WIDTH),
      .POS_W        (POS_W)
   ) u_clamp (
      .fin        (snap_ff),
      .stop       (snap_stop_ff),
      .value      (fin_value),
      .status     (fin_status),
      .end_offset (fin_end)
   );

   // result register
   assign rsp_valid_in = snap_move ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_move) begin
         rsp_value_ff  <= fin_value;
         rsp_status_ff <= fin_status;
         rsp_end_ff    <= fin_end;
      end
   end

   // a finished string never lands on a snapshot that has not moved on
   a_snap_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      snap_valid_ff && !snap_move |-> !step_fin)
      else $error("snapshot overwritten before transfer to result register");

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(MAX_STRING_LEN) && stop_ff <= pos_ff)
      else $error("position counter out of range");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step_fin |=> pos_ff == '0 && st_ff.phase == stip_pkg::PH_SPACE && !st_ff.any_digit)
      else $error("parse state not cleared after final byte");

   a_bad_base_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == stip_pkg::ST_BAD_BASE ||
                       rsp_status_ff == stip_pkg::ST_NONE)
      |-> rsp_value_ff == '0 && rsp_end_ff == '0)
      else $error("failed conversion with nonzero value or offset");

endmodule

// File: tb/stip_conversion_checker.sv
module stip_conversion_checker
   import stip_pkg::*;
#(
   parameter int OFFSET_W = 13,
   parameter int RSP_W    = 80
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] char_code
   input  logic                req_tlast,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [RSP_W-1:0]    rsp_tdata,   // value, status, end_offset
   input  logic                csr_we,
   input  logic [0:0]          csr_addr,
   input  logic [BASE_W-1:0]   csr_wdata,
   output int                  fail_count,
   output int                  pending
);

   localparam int STR_LIMIT = MAX_STRING_LEN_DEF;
   localparam logic [VALUE_W-1:0] U_MAX = '1;
   localparam logic [VALUE_W-1:0] S_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

   // rsp_tdata layout, lowest bits last
   typedef struct packed {
      logic [RSP_W-VALUE_W-2-OFFSET_W-1:0] pad;
      logic [OFFSET_W-1:0]                 end_offset;
      status_type                          status;
      logic [VALUE_W-1:0]                  value;
   } conversion_type;

   conversion_type      conversions[$];

   logic [BASE_W-1:0]   base_reg = BASE_RESET;
   logic                kind_reg = 1'b0;

   phase_type           phase = PH_SPACE;
   logic [VALUE_W-1:0]  acc = '0;
   logic                ovf = 1'b0;
   logic                negative = 1'b0;
   logic                seen_digit = 1'b0;
   logic [BASE_W-1:0]   radix = '0;
   logic [OFFSET_W-1:0] pos = '0;
   logic [OFFSET_W-1:0] stop_pos = '0;
   int                  mismatches = 0;

   initial begin
      fail_count = 0;
      pending = 0;
   end

   function automatic void restart_string();
      phase = PH_SPACE;
      acc = '0;
      ovf = 1'b0;
      negative = 1'b0;
      seen_digit = 1'b0;
      radix = '0;
      pos = '0;
      stop_pos = '0;
   endfunction

   function automatic int digit_value(input logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
      if (c >= CH_UP_A && c <= CH_UP_Z) return 10 + int'(c - CH_UP_A);
      if (c >= CH_LO_A && c <= CH_LO_Z) return 10 + int'(c - CH_LO_A);
      return 99;
   endfunction

   function automatic void accumulate(input logic [7:0] c);
      int                 d;
      logic [VALUE_W-1:0] b;
      d = digit_value(c);
      b = VALUE_W'(radix);
      if (radix >= BASE_TWO && d < int'(radix)) begin
         // exact test: acc * b + d fits only if acc <= (max - d) / b
         if (acc > (U_MAX - VALUE_W'(d)) / b) ovf = 1'b1;
         acc = acc * b + VALUE_W'(d);
         seen_digit = 1'b1;
         stop_pos = pos + 1'b1;
         phase = PH_DIGITS;
      end else begin
         phase = PH_DONE;
      end
   endfunction

   function automatic void begin_number(input logic [7:0] c);
      if (c == CH_ZERO && (radix == BASE_AUTO || radix == BASE_HEX)) begin
         // leading zero converts even if no prefix follows
         seen_digit = 1'b1;
         acc = '0;
         stop_pos = pos + 1'b1;
         phase = PH_ZERO;
      end else begin
         if (radix == BASE_AUTO) radix = BASE_DEC;
         accumulate(c);
      end
   endfunction

   function automatic conversion_type close_string();
      conversion_type r;
      r = '0;
      if (phase == PH_BADBASE) begin
         r.status = ST_BAD_BASE;
      end else if (!seen_digit) begin
         r.status = ST_NONE;
      end else begin
         r.end_offset = stop_pos;
         if (!kind_reg) begin
            if (!negative) begin
               if (ovf || acc > S_MAX) begin
                  r.value = S_MAX;
                  r.status = ST_RANGE;
               end else begin
                  r.value = acc;
               end
            end else if (ovf || acc > S_MAX + 1'b1) begin
               r.value = ~S_MAX;
               r.status = ST_RANGE;
            end else begin
               r.value = '0 - acc;
            end
         end else if (negative) begin
            // unsigned kind: negative clamps to zero, minus zero is fine
            if (ovf || acc != '0) r.status = ST_RANGE;
         end else if (ovf) begin
            r.value = U_MAX;
            r.status = ST_RANGE;
         end else begin
            r.value = acc;
         end
      end
      return r;
   endfunction

   function automatic void parse_char(input logic [7:0] code, input logic fin);
      logic [7:0] c;
      c = (pos >= STR_LIMIT) ? CH_NUL : code;
      if (pos == '0 && phase == PH_SPACE) begin
         radix = base_reg;
         if (radix == BASE_ONE || radix > BASE_MAX) phase = PH_BADBASE;
      end
      case (phase)
         PH_SPACE: begin
            if (c == CH_PLUS) begin
               phase = PH_SIGNED;
            end else if (c == CH_MINUS) begin
               negative = 1'b1;
               phase = PH_SIGNED;
            end else if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
               begin_number(c);
            end
         end
         PH_SIGNED: begin
            begin_number(c);
         end
         PH_ZERO: begin
            if (c == CH_LO_X || c == CH_UP_X) begin
               radix = BASE_HEX;
               phase = PH_HEXPFX;
            end else begin
               if (radix == BASE_AUTO) radix = BASE_OCT;
               accumulate(c);
            end
         end
         PH_HEXPFX, PH_DIGITS: begin
            accumulate(c);
         end
         default: ;
      endcase
      if (pos < STR_LIMIT) pos = pos + 1'b1;
      if (fin) begin
         conversions.push_back(close_string());
         restart_string();
      end
   endfunction

   always @(posedge clock) begin : monitor
      conversion_type got;
      conversion_type want;
      if (reset) begin
         base_reg = BASE_RESET;
         kind_reg = 1'b0;
         restart_string();
         conversions.delete();
         mismatches = 0;
      end else begin
         // result side first: a result never belongs to a byte taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            got = conversion_type'(rsp_tdata);
            if (conversions.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result transfer: value %h status %0d offset %0d",
                           got.value, got.status, got.end_offset);
            end else begin
               want = conversions.pop_front();
               if (got.value !== want.value || got.status !== want.status ||
                   got.end_offset !== want.end_offset) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result mismatch: expected value %h status %0d offset %0d, got value %h status %0d offset %0d",
                              want.value, want.status, want.end_offset,
                              got.value, got.status, got.end_offset);
               end
            end
         end
         if (req_tvalid && req_tready) parse_char(req_tdata, req_tlast);
         if (csr_we) begin
            if (csr_addr == CSR_NUMBER_BASE) base_reg = csr_wdata;
            else kind_reg = csr_wdata[0];
         end
      end
      fail_count <= mismatches;
      pending <= conversions.size();
   end

endmodule

// File: tb/tb_string_to_integer_parser_unit.sv
module tb_string_to_integer_parser_unit;
   import stip_pkg::*;

   localparam int POS_W      = $clog2(MAX_STRING_LEN_DEF + 1);
   localparam int RSP_W      = ((VALUE_W + 2 + POS_W + 7) / 8) * 8;
   localparam int IDLE_LIMIT = 2000;

   typedef logic [7:0] byte_q[$];

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata = '0;   // [7:0] char_code
   logic              req_tlast = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;        // value [63:0], status [65:64], end_offset [78:66]
   logic              csr_we = 1'b0;
   logic [0:0]        csr_addr = CSR_NUMBER_BASE;
   logic [BASE_W-1:0] csr_wdata = '0;

   int fail_count;
   int pending;
   int idle_cycles = 0;
   bit steady = 1'b0;

   logic [BASE_W-1:0] plan_base [0:10] = '{BASE_HEX, BASE_MAX, BASE_TWO, BASE_OCT, BASE_DEC,
                                           BASE_AUTO, BASE_ONE, 6'd37, 6'd63, BASE_MAX,
                                           BASE_TWO};
   logic              plan_kind [0:10] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1,
                                           1'b0, 1'b0, 1'b1};

   string_to_integer_parser_unit uut (.*);

   stip_conversion_checker #(.OFFSET_W(POS_W), .RSP_W(RSP_W)) conv_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // no progress on either channel for too long means a hang
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int draw_wait();
      return steady ? 0 : $urandom_range(0, 16);
   endfunction

   task automatic send_str(input byte_q chars);
      int gap;
      foreach (chars[i]) begin
         gap = draw_wait();
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= chars[i];
         req_tlast <= (i == chars.size() - 1);
         do @(posedge clock); while (!req_tready);
      end
      if ($urandom_range(0, 19) == 0) steady = !steady;
   endtask

   task automatic send_text(input string s);
      byte_q chars;
      for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
      send_str(chars);
   endtask

   // valid low, all results in, then a short wait for bytes that give no result
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_mode(input logic [BASE_W-1:0] base, input logic kind);
      logic [BASE_W-2:0] junk;
      junk = (BASE_W-1)'($urandom);
      drain();
      csr_we <= 1'b1;
      csr_addr <= CSR_NUMBER_BASE;
      csr_wdata <= base;
      @(posedge clock);
      csr_addr <= CSR_RESULT_KIND;
      csr_wdata <= {junk, kind};   // only bit 0 matters
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // mostly well-formed numbers with random content; some raw byte noise
   function automatic byte_q random_string(input logic [BASE_W-1:0] base);
      byte_q      chars;
      int         n;
      int         radix;
      int         r;
      int         d;
      logic [7:0] ch;
      if ($urandom_range(0, 9) < 2) begin
         n = $urandom_range(1, 6);
         repeat (n) chars.push_back(8'($urandom_range(0, 255)));
         return chars;
      end
      radix = (base == BASE_ONE || base > BASE_MAX) ? 10 : int'(base);
      repeat ($urandom_range(0, 3)) begin
         r = $urandom_range(0, 5);
         chars.push_back(r == 5 ? CH_SPACE : CH_TAB + 8'(r));
      end
      r = $urandom_range(0, 3);
      if (r < 2) begin
         chars.push_back(r == 0 ? CH_PLUS : CH_MINUS);
         if ($urandom_range(0, 7) == 0) chars.push_back(CH_SPACE);
      end
      if (radix == 0 || radix == 16) begin
         r = $urandom_range(0, 3);
         if (r < 3) chars.push_back(CH_ZERO);
         if (r < 2) begin
            chars.push_back(r == 0 ? CH_LO_X : CH_UP_X);
            radix = 16;
         end else if (radix == 0) begin
            radix = (r == 2) ? 8 : 10;
         end
      end
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 70) : $urandom_range(0, 8);
      repeat (n) begin
         d = ($urandom_range(0, 3) == 0) ? radix - 1 : $urandom_range(0, radix - 1);
         if (d < 10) ch = CH_ZERO + 8'(d);
         else ch = ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'(d - 10);
         chars.push_back(ch);
      end
      if ($urandom_range(0, 2) == 0) chars.push_back(8'($urandom_range(0, 255)));
      if (chars.size() == 0) chars.push_back(8'($urandom_range(0, 255)));
      return chars;
   endfunction

   task automatic run_random(input logic [BASE_W-1:0] base, input int budget);
      byte_q chars;
      int    count;
      count = 0;
      while (count < budget) begin
         chars = random_string(base);
         count += chars.size();
         send_str(chars);
      end
   endtask

   initial begin : result_sink
      int stall;
      @(negedge reset);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin : stimulus
      byte_q             chars;
      logic [BASE_W-1:0] base;
      logic              kind;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // power-on mode: base 10, signed
      send_text(" \t-42");
      send_text("9223372036854775807");
      send_text("-9223372036854775808");
      send_text("9223372036854775808");
      send_text("-9223372036854775809");
      send_text("99999999999999999999999");
      send_text("+");
      send_text("- 5");
      chars.push_back(CH_NUL);
      send_str(chars);
      chars.delete();
      chars.push_back(CH_ZERO + 8'd5);
      chars.push_back(8'h80);
      send_str(chars);

      set_mode(BASE_AUTO, 1'b1);
      send_text("0x1fz");
      send_text("0xg");
      send_text("017");
      send_text("0");
      send_text("-0");
      send_text("-1");
      send_text("18446744073709551615");
      send_text("18446744073709551616");
      send_text("0XFFFFFFFFFFFFFFFF");
      run_random(BASE_AUTO, 90);

      for (int i = 0; i < 15; i++) begin
         if (i < 11) begin
            base = plan_base[i];
            kind = plan_kind[i];
         end else begin
            base = BASE_W'($urandom_range(2, 36));
            kind = 1'($urandom_range(0, 1));
         end
         set_mode(base, kind);
         run_random(base, (base == BASE_ONE || base > BASE_MAX) ? 10 : 45);
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/stip_pkg.sv
hw/rtl/stip_step.sv
hw/rtl/stip_clamp.sv
hw/rtl/string_to_integer_parser_unit.sv
tb/stip_conversion_checker.sv
tb/tb_string_to_integer_parser_unit.sv
